FILE: hw/rtl/stbc_pkg.sv
package stbc_pkg;

   localparam int RUN_W = 8;
   localparam int CNT_W = 12;
   localparam int CSR_W = 12;
   localparam int IDX_W = 3;

   localparam logic [RUN_W-1:0] RUN_LENGTH_RST      = 8'd30;
   localparam logic [CNT_W-1:0] REPEAT_INTERVAL_RST = 12'd300;
   localparam logic [CNT_W-1:0] ERROR_LIMIT_RST     = 12'd3600;
   localparam logic [CNT_W-1:0] CNT_MAX             = 12'hFFF;

   typedef enum logic [1:0] {
      FUNC_TICK      = 2'd0,
      FUNC_UP_EDGE   = 2'd1,
      FUNC_LOW1_EDGE = 2'd2,
      FUNC_LOW2_EDGE = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      CTRL_IDLE   = 3'd0,
      CTRL_FILTER = 3'd1,
      CTRL_FIRST  = 3'd2,
      CTRL_CONT   = 3'd3,
      CTRL_ERROR  = 3'd4
   } ctrl_type;

   typedef enum logic [IDX_W-1:0] {
      CSR_OP_MODE         = 3'd0,
      CSR_MASTER_ON       = 3'd1,
      CSR_HEAT_ON         = 3'd2,
      CSR_RUN_LENGTH      = 3'd3,
      CSR_REPEAT_INTERVAL = 3'd4,
      CSR_ERROR_LIMIT     = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic             op_mode;
      logic             master_on;
      logic             heat_on;
      logic [RUN_W-1:0] run_length;
      logic [CNT_W-1:0] repeat_interval;
      logic [CNT_W-1:0] error_limit;
   } cfg_type;

   typedef struct packed {
      func_type func;
      logic     up_active;
      logic     down1_active;
      logic     down2_active;
   } item_type;

   typedef struct packed {
      logic             blow_on;
      logic             heater_on;
      logic [2:0]       ctrl_code;
      logic             getup_pulse;
      logic             birth_pulse;
      logic             timer_active;
      logic [RUN_W-1:0] run_remaining;
   } result_type;

   typedef struct packed {
      ctrl_type         ctrl;
      logic [RUN_W-1:0] run_left;
      logic [CNT_W-1:0] interval_count;
      logic [CNT_W-1:0] interval_phase;
      logic             seen_one;
      logic             seen_two;
      logic             timer;
   } state_type;

   function automatic state_type idle_state();
      state_type s;
      s.ctrl           = CTRL_IDLE;
      s.run_left       = '0;
      s.interval_count = '0;
      s.interval_phase = '0;
      s.seen_one       = 1'b0;
      s.seen_two       = 1'b0;
      s.timer          = 1'b0;
      return s;
   endfunction

   // reload the blower when a lower edge was latched
   function automatic state_type rearm(state_type s_in, logic [RUN_W-1:0] run_length);
      state_type s;
      s = s_in;
      if (s.seen_one || s.seen_two) begin
         s.run_left = run_length;
         s.seen_one = 1'b0;
         s.seen_two = 1'b0;
      end
      return s;
   endfunction

endpackage

FILE: hw/rtl/stbc_req_if.sv
interface stbc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic       up_active;
   logic       down1_active;
   logic       down2_active;

   modport source (output valid, output func, output up_active, output down1_active,
                   output down2_active, input ready);
   modport sink (input valid, input func, input up_active, input down1_active,
                 input down2_active, output ready);
endinterface

FILE: hw/rtl/stbc_rsp_if.sv
interface stbc_rsp_if;
   logic       valid;
   logic       ready;
   logic       blow_on;
   logic       heater_on;
   logic [2:0] ctrl_code;
   logic       getup_pulse;
   logic       birth_pulse;
   logic       timer_active;
   logic [7:0] run_remaining;

   modport source (output valid, output blow_on, output heater_on, output ctrl_code,
                   output getup_pulse, output birth_pulse, output timer_active,
                   output run_remaining, input ready);
   modport sink (input valid, input blow_on, input heater_on, input ctrl_code,
                 input getup_pulse, input birth_pulse, input timer_active,
                 input run_remaining, output ready);
endinterface

FILE: hw/rtl/stbc_cfg_regs.sv
module stbc_cfg_regs
   import stbc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_data,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OP_MODE:         cfg_in.op_mode         = csr_data[0];
            CSR_MASTER_ON:       cfg_in.master_on       = csr_data[0];
            CSR_HEAT_ON:         cfg_in.heat_on         = csr_data[0];
            CSR_RUN_LENGTH:      cfg_in.run_length      = csr_data[RUN_W-1:0];
            CSR_REPEAT_INTERVAL: cfg_in.repeat_interval = csr_data[CNT_W-1:0];
            CSR_ERROR_LIMIT:     cfg_in.error_limit     = csr_data[CNT_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.op_mode         <= 1'b0;
         cfg_ff.master_on       <= 1'b0;
         cfg_ff.heat_on         <= 1'b0;
         cfg_ff.run_length      <= RUN_LENGTH_RST;
         cfg_ff.repeat_interval <= REPEAT_INTERVAL_RST;
         cfg_ff.error_limit     <= ERROR_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/stbc_core.sv
module stbc_core
   import stbc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  item_type   item,
   input  logic       step_en,
   output result_type result
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_type s;
      logic      getup;
      logic      birth;
      logic      blower;
      s     = state_ff;
      getup = 1'b0;
      birth = 1'b0;
      case (item.func) inside
         FUNC_UP_EDGE: begin
            if (item.up_active && !cfg.op_mode) begin
               s.timer    = 1'b1;
               s.ctrl     = CTRL_FILTER;
               s.run_left = cfg.run_length;
            end
         end
         FUNC_LOW1_EDGE, FUNC_LOW2_EDGE: begin
            if (item.func == FUNC_LOW1_EDGE) begin
               s.seen_one = 1'b1;
            end else begin
               s.seen_two = 1'b1;
            end
            if (cfg.op_mode) begin
               s.run_left = '0;
               s.timer    = 1'b1;
            end
         end
         default: begin
            if (s.timer && !cfg.op_mode) begin
               if (s.ctrl == CTRL_FILTER) begin
                  s.ctrl = CTRL_FIRST;
                  if (!item.up_active) begin
                     s = idle_state();
                  end else begin
                     getup = 1'b1;
                     s     = rearm(s, cfg.run_length);
                  end
               end
               if (s.ctrl == CTRL_FIRST) begin
                  if (!item.up_active) begin
                     s = idle_state();
                  end else begin
                     s = rearm(s, cfg.run_length);
                  end
               end
               if (s.ctrl == CTRL_CONT) begin
                  if (!item.up_active) begin
                     s = idle_state();
                  end else begin
                     s = rearm(s, cfg.run_length);
                     if (item.down1_active || item.down2_active) begin
                        if (s.run_left == '0) begin
                           if (s.interval_count != CNT_MAX) begin
                              s.interval_count = s.interval_count + 1'b1;
                           end
                           s.interval_phase = s.interval_phase + 1'b1;
                           if (s.interval_phase >= cfg.repeat_interval) begin
                              s.interval_phase = '0;
                              s.run_left       = cfg.run_length;
                           end
                           if (s.interval_count == cfg.error_limit) begin
                              s.ctrl = CTRL_ERROR;
                           end
                        end
                     end else begin
                        s.interval_count = '0;
                        s.interval_phase = '0;
                     end
                  end
               end
               if (s.run_left != '0) begin
                  s.run_left = s.run_left - 1'b1;
                  if (s.run_left == RUN_W'(1)) begin
                     s.ctrl = CTRL_CONT;
                  end
               end
            end else if (s.timer) begin
               if (s.seen_one || s.seen_two) begin
                  s.seen_one = 1'b0;
                  s.seen_two = 1'b0;
                  birth      = 1'b1;
               end else begin
                  s.timer = 1'b0;
               end
            end
         end
      endcase

      blower                = cfg.master_on && (s.run_left != '0);
      state_in              = s;
      result.blow_on        = blower;
      result.heater_on      = blower && cfg.heat_on;
      result.ctrl_code      = s.ctrl;
      result.getup_pulse    = getup;
      result.birth_pulse    = birth;
      result.timer_active   = s.timer;
      result.run_remaining  = s.run_left;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= idle_state();
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/sensor_timed_blower_controller.sv
// The request is held in the input register, then the core steps it and the result is held in the output register.
// Throughput: one request per cycle, sustained while rsp_ch is ready.
// The input register lets a new request enter while a result waits in the result register.
// Reset (synchronous, active high): controller idle, timer stopped,
// countdown and counters zero, registers at their default values.
module sensor_timed_blower_controller
   import stbc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   stbc_req_if.sink         req_ch,
   stbc_rsp_if.source       rsp_ch,
   input  logic             csr_wr_en,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_data
);

   cfg_type    cfg;
   result_type step_result;

   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   in_item_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_result_ff;
   logic       advance;
   logic       req_take;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.func         <= func_type'(req_ch.func);
         in_item_ff.up_active    <= req_ch.up_active;
         in_item_ff.down1_active <= req_ch.down1_active;
         in_item_ff.down2_active <= req_ch.down2_active;
      end
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   stbc_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   stbc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (in_item_ff),
      .step_en (advance),
      .result  (step_result)
   );

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.blow_on       = out_result_ff.blow_on;
   assign rsp_ch.heater_on     = out_result_ff.heater_on;
   assign rsp_ch.ctrl_code     = out_result_ff.ctrl_code;
   assign rsp_ch.getup_pulse   = out_result_ff.getup_pulse;
   assign rsp_ch.birth_pulse   = out_result_ff.birth_pulse;
   assign rsp_ch.timer_active  = out_result_ff.timer_active;
   assign rsp_ch.run_remaining = out_result_ff.run_remaining;

endmodule

FILE: hw/rtl/stbc_checker.sv
module stbc_checker
   import stbc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_blow_on,
   input logic             rsp_heater_on,
   input logic [2:0]       rsp_ctrl_code,
   input logic             rsp_getup_pulse,
   input logic             rsp_birth_pulse,
   input logic             rsp_timer_active,
   input logic [RUN_W-1:0] rsp_run_remaining
);

   // a stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_heater_needs_blower: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_heater_on |-> rsp_blow_on)
      else $error("heater on without blower");

   a_blower_needs_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_blow_on |-> rsp_run_remaining != '0)
      else $error("blower on with empty countdown");

   a_getup_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_getup_pulse |->
         rsp_timer_active && !rsp_birth_pulse &&
         (rsp_ctrl_code == CTRL_FIRST || rsp_ctrl_code == CTRL_CONT))
      else $error("getup pulse outside first run");

   a_birth_timer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_birth_pulse |-> rsp_timer_active)
      else $error("birth pulse with timer stopped");

endmodule

bind sensor_timed_blower_controller stbc_checker u_stbc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_blow_on       (rsp_ch.blow_on),
   .rsp_heater_on     (rsp_ch.heater_on),
   .rsp_ctrl_code     (rsp_ch.ctrl_code),
   .rsp_getup_pulse   (rsp_ch.getup_pulse),
   .rsp_birth_pulse   (rsp_ch.birth_pulse),
   .rsp_timer_active  (rsp_ch.timer_active),
   .rsp_run_remaining (rsp_ch.run_remaining)
);

FILE: bench/tb_sensor_timed_blower_controller.sv
`timescale 1ns / 1ps
module tb_sensor_timed_blower_controller;
   import stbc_pkg::*;

   localparam int HALF_PERIOD  = 2;
   localparam int RESET_CYCLES = 7;
   localparam int SETTLE       = 4;
   localparam int CYCLE_LIMIT  = 200000;

   // indexes with no register behind them
   localparam logic [IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en;
   logic [IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_data;

   stbc_req_if req_ch();
   stbc_rsp_if rsp_ch();

   sensor_timed_blower_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // controller settings as the block should hold them
   logic             cfg_production;
   logic             cfg_master;
   logic             cfg_heat;
   logic [RUN_W-1:0] cfg_run;
   logic [CNT_W-1:0] cfg_repeat;
   logic [CNT_W-1:0] cfg_limit;

   // controller state as the block should hold it
   ctrl_type         ctl_state;
   logic [RUN_W-1:0] blow_left;
   logic [CNT_W-1:0] active_ticks;
   logic [CNT_W-1:0] repeat_phase;
   logic             edge_one;
   logic             edge_two;
   logic             tick_timer;

   item_type   pending_q[$];
   result_type outputs_q[$];
   item_type   in_flight;
   result_type want;
   int         send_idle_pct;
   int         recv_idle_pct;
   int         faults;
   int         cycles;
   int         issued;
   int         checked;

   function automatic void clear_controller();
      ctl_state    = CTRL_IDLE;
      blow_left    = '0;
      edge_one     = 1'b0;
      edge_two     = 1'b0;
      active_ticks = '0;
      repeat_phase = '0;
      tick_timer   = 1'b0;
   endfunction

   function automatic void reload_on_edge();
      if (edge_one || edge_two) begin
         blow_left = cfg_run;
         edge_one  = 1'b0;
         edge_two  = 1'b0;
      end
   endfunction

   function automatic result_type blower_step(item_type it);
      result_type r;
      logic       getup;
      logic       birth;
      logic       blow;
      getup = 1'b0;
      birth = 1'b0;
      case (it.func) inside
         FUNC_UP_EDGE: begin
            if (it.up_active && !cfg_production) begin
               tick_timer = 1'b1;
               ctl_state  = CTRL_FILTER;
               blow_left  = cfg_run;
            end
         end
         FUNC_LOW1_EDGE, FUNC_LOW2_EDGE: begin
            if (it.func == FUNC_LOW1_EDGE)
               edge_one = 1'b1;
            else
               edge_two = 1'b1;
            if (cfg_production) begin
               blow_left  = '0;
               tick_timer = 1'b1;
            end
         end
         default: begin
            if (tick_timer && cfg_production) begin
               if (edge_one || edge_two) begin
                  edge_one = 1'b0;
                  edge_two = 1'b0;
                  birth    = 1'b1;
               end else begin
                  tick_timer = 1'b0;
               end
            end else if (tick_timer) begin
               if (ctl_state == CTRL_FILTER) begin
                  ctl_state = CTRL_FIRST;
                  if (!it.up_active) begin
                     clear_controller();
                  end else begin
                     getup = 1'b1;
                     reload_on_edge();
                  end
               end
               if (ctl_state == CTRL_FIRST) begin
                  if (!it.up_active)
                     clear_controller();
                  else
                     reload_on_edge();
               end
               if (ctl_state == CTRL_CONT) begin
                  if (!it.up_active) begin
                     clear_controller();
                  end else begin
                     reload_on_edge();
                     if (it.down1_active || it.down2_active) begin
                        if (blow_left == 0) begin
                           if (active_ticks != CNT_MAX)
                              active_ticks = active_ticks + 1'b1;
                           repeat_phase = repeat_phase + 1'b1;
                           if (repeat_phase >= cfg_repeat) begin
                              repeat_phase = '0;
                              blow_left    = cfg_run;
                           end
                           if (active_ticks == cfg_limit)
                              ctl_state = CTRL_ERROR;
                        end
                     end else begin
                        active_ticks = '0;
                        repeat_phase = '0;
                     end
                  end
               end
               if (blow_left != 0) begin
                  blow_left = blow_left - 1'b1;
                  if (blow_left == 1)
                     ctl_state = CTRL_CONT;
               end
            end
         end
      endcase
      blow            = cfg_master && (blow_left != 0);
      r.blow_on       = blow;
      r.heater_on     = blow && cfg_heat;
      r.ctrl_code     = ctl_state;
      r.getup_pulse   = getup;
      r.birth_pulse   = birth;
      r.timer_active  = tick_timer;
      r.run_remaining = blow_left;
      return r;
   endfunction

   function automatic item_type make_event(func_type f, logic up, logic d1, logic d2);
      item_type it;
      it.func         = f;
      it.up_active    = up;
      it.down1_active = d1;
      it.down2_active = d2;
      return it;
   endfunction

   // mostly sessions that stay on the upper sensor outside production mode, with lower edges and drop-outs mixed in
   function automatic item_type random_event(logic production);
      item_type    it;
      int unsigned roll;
      roll            = $urandom_range(0, 99);
      it.up_active    = production ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 99) < 96);
      it.down1_active = ($urandom_range(0, 99) < 65);
      it.down2_active = ($urandom_range(0, 99) < 50);
      if (production) begin
         if (roll < 20)
            it.func = FUNC_LOW1_EDGE;
         else if (roll < 40)
            it.func = FUNC_LOW2_EDGE;
         else if (roll < 50)
            it.func = FUNC_UP_EDGE;
         else
            it.func = FUNC_TICK;
      end else begin
         if (roll < 5)
            it.func = FUNC_UP_EDGE;
         else if (roll < 10)
            it.func = FUNC_LOW1_EDGE;
         else if (roll < 15)
            it.func = FUNC_LOW2_EDGE;
         else
            it.func = FUNC_TICK;
      end
      return it;
   endfunction

   function automatic void check_field(string name, int unsigned exp, int unsigned got);
      if (exp != got) begin
         $error("%s: expected %0d, got %0d", name, exp, got);
         faults++;
      end
   endfunction

   task automatic write_csr(input logic [IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_OP_MODE:         cfg_production = val[0];
         CSR_MASTER_ON:       cfg_master     = val[0];
         CSR_HEAT_ON:         cfg_heat       = val[0];
         CSR_RUN_LENGTH:      cfg_run        = val[RUN_W-1:0];
         CSR_REPEAT_INTERVAL: cfg_repeat     = val;
         CSR_ERROR_LIMIT:     cfg_limit      = val;
         default: ;
      endcase
   endtask

   task automatic configure(input logic mode, input logic [CSR_W-1:0] master,
                            input logic [CSR_W-1:0] heat, input logic [CSR_W-1:0] run,
                            input logic [CSR_W-1:0] rep, input logic [CSR_W-1:0] lim);
      write_csr(CSR_OP_MODE, {{(CSR_W-1){1'b0}}, mode});
      write_csr(CSR_MASTER_ON, master);
      write_csr(CSR_HEAT_ON, heat);
      write_csr(CSR_RUN_LENGTH, run);
      write_csr(CSR_REPEAT_INTERVAL, rep);
      write_csr(CSR_ERROR_LIMIT, lim);
   endtask

   task automatic drain();
      while (pending_q.size() != 0 || issued != checked)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic run_phase(input logic production, input int count);
      repeat (count) pending_q.push_back(random_event(production));
      drain();
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            outputs_q.push_back(blower_step(in_flight));
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               in_flight             = pending_q.pop_front();
               issued++;
               req_ch.func          <= in_flight.func;
               req_ch.up_active     <= in_flight.up_active;
               req_ch.down1_active  <= in_flight.down1_active;
               req_ch.down2_active  <= in_flight.down2_active;
               req_ch.valid         <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (outputs_q.size() == 0) begin
               $error("result with no request outstanding");
               faults++;
            end else begin
               want = outputs_q.pop_front();
               checked++;
               check_field("blow_on", want.blow_on, rsp_ch.blow_on);
               check_field("heater_on", want.heater_on, rsp_ch.heater_on);
               check_field("ctrl_code", want.ctrl_code, rsp_ch.ctrl_code);
               check_field("getup_pulse", want.getup_pulse, rsp_ch.getup_pulse);
               check_field("birth_pulse", want.birth_pulse, rsp_ch.birth_pulse);
               check_field("timer_active", want.timer_active, rsp_ch.timer_active);
               check_field("run_remaining", want.run_remaining, rsp_ch.run_remaining);
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_sensor_timed_blower_controller failed");
         $finish;
      end
   end

   initial begin
      logic d1;
      req_ch.valid        = 1'b0;
      req_ch.func         = FUNC_TICK;
      req_ch.up_active    = 1'b0;
      req_ch.down1_active = 1'b0;
      req_ch.down2_active = 1'b0;
      rsp_ch.ready        = 1'b0;
      csr_wr_en           = 1'b0;
      csr_index           = CSR_OP_MODE;
      csr_data            = '0;
      cycles              = 0;
      faults              = 0;
      issued              = 0;
      checked             = 0;
      send_idle_pct       = 9;
      recv_idle_pct       = 76;
      cfg_production      = 1'b0;
      cfg_master          = 1'b0;
      cfg_heat            = 1'b0;
      cfg_run             = RUN_LENGTH_RST;
      cfg_repeat          = REPEAT_INTERVAL_RST;
      cfg_limit           = ERROR_LIMIT_RST;
      clear_controller();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: stopped timer, ignored upper edge, filter drop-out
      pending_q.push_back(make_event(FUNC_TICK, 1, 1, 1));
      pending_q.push_back(make_event(FUNC_UP_EDGE, 0, 0, 0));
      pending_q.push_back(make_event(FUNC_LOW1_EDGE, 0, 1, 0));
      pending_q.push_back(make_event(FUNC_UP_EDGE, 1, 0, 0));
      pending_q.push_back(make_event(FUNC_TICK, 0, 0, 0));
      drain();

      // oversized data gets masked, spare indexes do nothing
      configure(1'b0, 12'h003, 12'h001, 12'hF03, 12'd2, 12'd3);
      write_csr(CSR_SPARE_LO, 12'hFFF);
      write_csr(CSR_SPARE_HI, 12'hFFF);

      // full postpartum walk into error and back out
      pending_q.push_back(make_event(FUNC_UP_EDGE, 1, 0, 0));
      pending_q.push_back(make_event(FUNC_LOW2_EDGE, 1, 0, 1));
      pending_q.push_back(make_event(FUNC_TICK, 1, 0, 0));
      pending_q.push_back(make_event(FUNC_TICK, 1, 0, 0));
      pending_q.push_back(make_event(FUNC_TICK, 1, 1, 0));
      pending_q.push_back(make_event(FUNC_TICK, 1, 1, 0));
      pending_q.push_back(make_event(FUNC_TICK, 1, 0, 1));
      pending_q.push_back(make_event(FUNC_TICK, 1, 1, 1));
      pending_q.push_back(make_event(FUNC_TICK, 1, 1, 0));
      pending_q.push_back(make_event(FUNC_TICK, 1, 1, 0));
      pending_q.push_back(make_event(FUNC_TICK, 0, 0, 0));
      pending_q.push_back(make_event(FUNC_UP_EDGE, 1, 0, 0));
      pending_q.push_back(make_event(FUNC_TICK, 1, 0, 0));
      pending_q.push_back(make_event(FUNC_TICK, 0, 0, 0));
      drain();

      // production: birth report, then timer stop
      write_csr(CSR_OP_MODE, 12'd1);
      pending_q.push_back(make_event(FUNC_TICK, 0, 0, 0));
      pending_q.push_back(make_event(FUNC_LOW1_EDGE, 0, 1, 0));
      pending_q.push_back(make_event(FUNC_UP_EDGE, 1, 0, 0));
      pending_q.push_back(make_event(FUNC_TICK, 0, 1, 0));
      pending_q.push_back(make_event(FUNC_TICK, 0, 0, 0));
      pending_q.push_back(make_event(FUNC_LOW2_EDGE, 1, 0, 1));
      pending_q.push_back(make_event(FUNC_TICK, 1, 1, 1));
      drain();

      configure(1'b0, 12'd1, 12'd1, 12'd5, 12'd3, 12'd6);
      run_phase(1'b0, 200);
      configure(1'b0, 12'd1, 12'd0, 12'd2, 12'd1, 12'd4095);
      run_phase(1'b0, 100);
      run_phase(1'b0, 100);

      send_idle_pct = 76;
      recv_idle_pct = 9;
      configure(1'b1, 12'd1, 12'd1, 12'd7, 12'd4095, 12'd1);
      run_phase(1'b1, 200);
      configure(1'b0, 12'd0, 12'd1, 12'd255, 12'd2, 12'd10);
      run_phase(1'b0, 200);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(1'b0, 12'd1, 12'd1, 12'd1, 12'd0, 12'd0);
      run_phase(1'b0, 200);
      configure(1'b0, 12'd1, 12'd1, 12'd0, 12'd5, 12'd3);
      run_phase(1'b0, 200);

      // long lower-sensor stretch with no limit set
      configure(1'b0, 12'd1, 12'd0, 12'd2, 12'd4095, 12'd0);
      pending_q.push_back(make_event(FUNC_UP_EDGE, 1, 0, 0));
      repeat (250) begin
         d1 = $urandom_range(0, 1);
         pending_q.push_back(make_event(FUNC_TICK, 1, d1,
                                        d1 ? logic'($urandom_range(0, 1)) : 1'b1));
      end
      drain();
      // top limit set mid-run, then drop-out and restart
      write_csr(CSR_ERROR_LIMIT, 12'd4095);
      pending_q.push_back(make_event(FUNC_TICK, 1, 1, 0));
      pending_q.push_back(make_event(FUNC_TICK, 0, 0, 1));
      pending_q.push_back(make_event(FUNC_UP_EDGE, 1, 1, 1));
      pending_q.push_back(make_event(FUNC_TICK, 1, 0, 0));
      drain();

      if (faults == 0 && outputs_q.size() == 0)
         $display("tb_sensor_timed_blower_controller passed");
      else
         $display("tb_sensor_timed_blower_controller failed");
      $finish;
   end

endmodule
